// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared forms for the concurrent checks of the walker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising edge, off while reset is low
`define FSBW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("walker check failed");

// overlapping implication
`define FSBW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("walker check failed");

`endif

// ===== rtl/core/fsbw_pkg.sv =====
// ----------------------------------------------------------------------------
// fsbw_pkg
// types and constants shared by the structure block walker
// ----------------------------------------------------------------------------
package fsbw_pkg;

  // nesting limit and the widths that follow from it
  localparam int MaxDepth  = 64;
  localparam int DepthW    = $clog2(MaxDepth + 1);
  localparam int DepthOutW = 7;

  localparam int WordW    = 32;
  localparam int StrSizeW = 24;
  localparam int WordsW   = 20;
  localparam int NeedW    = 31;
  localparam int PlenW    = 32;
  localparam int NoffW    = 24;
  localparam int EventW   = 3;
  localparam int CfgW     = 24;
  localparam int CfgIdxW  = 1;

  localparam int OutFieldsW = DepthOutW + PlenW + NoffW;
  localparam int OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // token codes of the structure block
  localparam logic [WordW-1:0] TokBeginNode = 32'h0000_0001;
  localparam logic [WordW-1:0] TokEndNode   = 32'h0000_0002;
  localparam logic [WordW-1:0] TokProp      = 32'h0000_0003;
  localparam logic [WordW-1:0] TokNop       = 32'h0000_0004;

  // event codes on the result channel
  localparam logic [EventW-1:0] EvBusy  = 3'd0;
  localparam logic [EventW-1:0] EvBegin = 3'd1;
  localparam logic [EventW-1:0] EvEnd   = 3'd2;
  localparam logic [EventW-1:0] EvProp  = 3'd3;
  localparam logic [EventW-1:0] EvNop   = 3'd4;
  localparam logic [EventW-1:0] EvDone  = 3'd5;
  localparam logic [EventW-1:0] EvError = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStringsSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStructWords = 1'b1;

  // one classified word as it waits between front and back
  typedef struct packed {
    logic             restart;
    logic             tok_begin;
    logic             tok_end;
    logic             tok_prop;
    logic             tok_nop;
    logic             zero_byte;
    logic             off_bad;
    logic [NeedW-1:0] need;
    logic [WordW-1:0] word;
  } item_t;

  // low bits of the depth as carried on the result channel
  function automatic logic [DepthOutW-1:0] depth_field(input logic [DepthW-1:0] d);
    logic [DepthW+DepthOutW-1:0] ext;
    ext = {{DepthOutW{1'b0}}, d};
    return ext[DepthOutW-1:0];
  endfunction

endpackage

// ===== rtl/core/fdt_structure_block_walker.sv =====
// ----------------------------------------------------------------------------
// fdt_structure_block_walker
// streaming walker over the words of a device-tree structure block
// ----------------------------------------------------------------------------
// The walker takes one big-endian 32-bit structure word per request and
// returns exactly one result per word: busy, node begin, node end, property
// (with its value length and name offset), nop, subtree done or error. A walk
// starts inside a node at depth one; a word with the restart flag begins a
// new walk. Node begin is reported on the name word holding a zero byte,
// property on its name-offset word; value words report busy. After subtree
// done or an error every further word repeats that event until restart.
// Sustained rate is one word per clock while results are taken: the front
// classifies a word as it arrives, a two-entry queue holds classified words,
// and the back updates the parse state and loads the result register
// together, which is what sets the rate. A taken word is written into the
// queue, and the back then loads its result into the result register, from
// which the result request is offered.
// The two configuration registers must be written while the walker is idle.
// ----------------------------------------------------------------------------
module fdt_structure_block_walker import fsbw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // configuration writes, no read-back
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,

  // structure words in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WordW-1:0]     s_axis_tdata,   // word
  input  logic                 s_axis_tuser,   // restart

  // results out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // depth_now, prop_length, name_offset
  output logic [EventW-1:0]    m_axis_tuser    // event_res
);

  // configuration registers
  logic [StrSizeW-1:0] strings_size_q;
  logic [WordsW-1:0]   struct_words_q;

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strings_size_q <= '0;
      struct_words_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStringsSize: strings_size_q <= cfg_wdata_i[StrSizeW-1:0];
        CfgStructWords: struct_words_q <= cfg_wdata_i[WordsW-1:0];
        default: ;
      endcase
    end
  end

  // a request is taken whenever the queue has a free entry
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // front: token decode, zero-byte search, name offset bound, padded length
  fsbw_front u_front (
    .word_i         (s_axis_tdata),
    .restart_i      (s_axis_tuser),
    .strings_size_i (strings_size_q),
    .item_o         (front_item)
  );

  // decouples the front from a stalled result channel
  fsbw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // back: phase machine, depth and word counting, result register
  fsbw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .q_pop_o        (q_pop),
    .struct_words_i (struct_words_q),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_event_o    (m_axis_tuser),
    .res_data_o     (m_axis_tdata)
  );

endmodule

// ===== rtl/core/fsbw_front.sv =====
// ----------------------------------------------------------------------------
// fsbw_front
// classifies each incoming word before it is queued
// ----------------------------------------------------------------------------
module fsbw_front import fsbw_pkg::*; (
  input  logic [WordW-1:0]    word_i,
  input  logic                restart_i,
  input  logic [StrSizeW-1:0] strings_size_i,
  output item_t               item_o
);

  logic [WordW:0] len_round;

  // padded length in words, used if this word turns out to be a length
  assign len_round = {1'b0, word_i} + (WordW + 1)'(3);

  always_comb begin
    item_o.restart   = restart_i;
    item_o.tok_begin = (word_i == TokBeginNode);
    item_o.tok_end   = (word_i == TokEndNode);
    item_o.tok_prop  = (word_i == TokProp);
    item_o.tok_nop   = (word_i == TokNop);
    item_o.zero_byte = (word_i[7:0] == 8'h00) || (word_i[15:8] == 8'h00) ||
                       (word_i[23:16] == 8'h00) || (word_i[31:24] == 8'h00);
    item_o.off_bad   = (word_i >= {{(WordW-StrSizeW){1'b0}}, strings_size_i});
    item_o.need      = len_round[WordW:2];
    item_o.word      = word_i;
  end

endmodule

// ===== rtl/core/fsbw_queue.sv =====
// ----------------------------------------------------------------------------
// fsbw_queue
// short first-in first-out queue of classified words
// ----------------------------------------------------------------------------
module fsbw_queue import fsbw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    if (p == QPtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/core/fsbw_back.sv =====
// ----------------------------------------------------------------------------
// fsbw_back
// parse phase machine and result register
// ----------------------------------------------------------------------------
module fsbw_back import fsbw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  input  logic [WordsW-1:0]    struct_words_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [EventW-1:0]    res_event_o,
  output logic [OutTdataW-1:0] res_data_o
);

  localparam logic [2:0] PhToken = 3'd0;
  localparam logic [2:0] PhName  = 3'd1;
  localparam logic [2:0] PhLen   = 3'd2;
  localparam logic [2:0] PhOff   = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhDone  = 3'd5;
  localparam logic [2:0] PhError = 3'd6;

  logic [2:0]        phase_q, phase_d, ph_eff;
  logic [DepthW-1:0] depth_q, depth_d, depth_eff;
  logic [WordsW-1:0] left_q, left_d, left_eff;
  logic [WordsW-1:0] used_q, used_d, used_eff, used_inc, room;
  logic [PlenW-1:0]  hlen_q, hlen_d;
  logic [NeedW-1:0]  hneed_q, hneed_d;

  logic                 valid_q;
  logic [EventW-1:0]    event_q, ev;
  logic [OutTdataW-1:0] data_q;
  logic [PlenW-1:0]     plen;
  logic [NoffW-1:0]     noff;
  logic                 take;

  assign take        = q_valid_i && (!valid_q || res_ready_i);
  assign q_pop_o     = take;
  assign res_valid_o = valid_q;
  assign res_event_o = event_q;
  assign res_data_o  = data_q;

  always_comb begin
    // a restart word begins a fresh walk before it is looked at
    ph_eff    = q_item_i.restart ? PhToken : phase_q;
    depth_eff = q_item_i.restart ? DepthW'(1) : depth_q;
    left_eff  = q_item_i.restart ? '0 : left_q;
    used_eff  = q_item_i.restart ? '0 : used_q;
    used_inc  = used_eff + 1'b1;
    room      = struct_words_i - used_inc;

    phase_d = ph_eff;
    depth_d = depth_eff;
    left_d  = left_eff;
    used_d  = used_eff;
    hlen_d  = hlen_q;
    hneed_d = hneed_q;
    ev      = EvBusy;
    plen    = '0;
    noff    = '0;

    if (ph_eff == PhDone) begin
      ev = EvDone;
    end else if (ph_eff == PhError) begin
      ev = EvError;
    end else if (used_eff >= struct_words_i) begin
      phase_d = PhError;
      ev      = EvError;
    end else begin
      used_d = used_inc;
      case (ph_eff)
        PhToken: begin
          if (q_item_i.tok_begin) begin
            if (depth_eff >= DepthW'(MaxDepth)) begin
              phase_d = PhError;
              ev      = EvError;
            end else begin
              phase_d = PhName;
            end
          end else if (q_item_i.tok_end) begin
            depth_d = (depth_eff != '0) ? depth_eff - 1'b1 : '0;
            if (depth_d == '0) begin
              phase_d = PhDone;
              ev      = EvDone;
            end else begin
              ev = EvEnd;
            end
          end else if (q_item_i.tok_prop) begin
            phase_d = PhLen;
          end else if (q_item_i.tok_nop) begin
            ev = EvNop;
          end else begin
            phase_d = PhError;
            ev      = EvError;
          end
        end
        PhName: begin
          if (q_item_i.zero_byte) begin
            depth_d = depth_eff + 1'b1;
            phase_d = PhToken;
            ev      = EvBegin;
          end
        end
        PhLen: begin
          hlen_d  = q_item_i.word;
          hneed_d = q_item_i.need;
          phase_d = PhOff;
        end
        PhOff: begin
          if (q_item_i.off_bad || (hneed_q > {{(NeedW-WordsW){1'b0}}, room})) begin
            phase_d = PhError;
            ev      = EvError;
          end else begin
            ev     = EvProp;
            plen   = hlen_q;
            noff   = q_item_i.word[NoffW-1:0];
            // need fits the room here, so the low bits carry it all
            left_d = hneed_q[WordsW-1:0];
            phase_d = (hneed_q != '0) ? PhData : PhToken;
          end
        end
        default: begin
          if (left_eff != '0) begin
            left_d = left_eff - 1'b1;
          end
          if (left_d == '0) begin
            phase_d = PhToken;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhToken;
      depth_q <= DepthW'(1);
      left_q  <= '0;
      used_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        depth_q <= depth_d;
        left_q  <= left_d;
        used_q  <= used_d;
        valid_q <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hlen_q  <= hlen_d;
      hneed_q <= hneed_d;
      event_q <= ev;
      data_q  <= OutTdataW'({noff, plen, depth_field(depth_d)});
    end
  end

endmodule

// ===== rtl/core/fsbw_checker.sv =====
// ----------------------------------------------------------------------------
// fsbw_checker
// port-level checks of the structure block walker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsbw_checker import fsbw_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CfgIdxW-1:0]   cfg_idx_i,
  input logic [CfgW-1:0]      cfg_wdata_i,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [WordW-1:0]     s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic [EventW-1:0]    m_axis_tuser
);

  // copy of the strings size as seen on the configuration port
  logic [StrSizeW-1:0] str_size_q;
  logic                prop_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_size_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CfgStringsSize)) begin
      str_size_q <= cfg_wdata_i[StrSizeW-1:0];
    end
  end

  assign prop_ev = m_axis_tvalid && (m_axis_tuser == EvProp);

  // a stalled result holds
  `FSBW_ASSERT(a_res_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // length and offset are zero unless a property is reported
  `FSBW_ASSERT_IMP(a_prop_fields_zero, clk_i, rst_ni, m_axis_tvalid && !prop_ev, m_axis_tdata[DepthOutW +: (PlenW + NoffW)] == '0)

  // a reported name offset lies inside the strings block
  `FSBW_ASSERT_IMP(a_offset_bound, clk_i, rst_ni, prop_ev, m_axis_tdata[(DepthOutW + PlenW) +: NoffW] < str_size_q)

  // subtree done comes only back at depth zero
  `FSBW_ASSERT_IMP(a_done_depth, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == EvDone), m_axis_tdata[DepthOutW-1:0] == '0)

endmodule

bind fdt_structure_block_walker fsbw_checker u_fsbw_checker (.*);
